// File: src/sfla_pkg.sv
package sfla_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;
  localparam logic [1:0] ST_DOUBLE     = 2'd3;

  localparam int unsigned CAP_W     = 11;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned CAP_RESET = 1024;
  localparam logic [CAP_W-1:0] COUNT_MAX = 11'h7FF;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot_index;
  } sfla_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic [1:0]        status;
    logic [CAP_W-1:0]  used_count;
  } sfla_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_we;
    logic accept;
    logic exec;
  } sfla_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
  } sfla_stat_t;

endpackage

// File: src/slot_free_list_allocator_core.sv
// Channel   Handshake                 Payload
// command   start / busy              in_item_i (cmd, slot_index)
// result    res_valid_o, one cycle    res_o (granted_slot, status, used_count)
// config    cfg_we_i                  cfg_wdata_i (pool_capacity)
//
// The link memory has one port, so the link is read in the accept cycle and
// written back in the following cycle.
// After reset and after every capacity write the links are rebuilt by a sweep
// over all POOL_DEPTH entries, one entry per cycle, with busy held high.
// The result appears in the cycle after the item is processed; the receiver
// cannot stall, so the next item may be accepted while a result is shown.
module slot_free_list_allocator_core import sfla_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sfla_in_t         in_item_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output logic             res_valid_o,
  output sfla_out_t        res_o
);

  sfla_ctrl_t ctrl;
  sfla_stat_t stat;

  sfla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cfg_we_i (cfg_we_i),
    .stat_i   (stat),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  sfla_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// File: src/sfla_ctrl.sv
module sfla_ctrl import sfla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       cfg_we_i,
  input  sfla_stat_t stat_i,
  output sfla_ctrl_t ctrl_o,
  output logic       busy
);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
    // A capacity write always restarts the link rebuild.
    if (cfg_we_i) state_d = S_INIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctrl_o.init_we = (state_q == S_INIT);
  assign ctrl_o.accept  = (state_q == S_IDLE) && start;
  assign ctrl_o.exec    = (state_q == S_EXEC);
  assign busy           = (state_q != S_IDLE);

endmodule

// File: src/sfla_datapath.sv
module sfla_datapath import sfla_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfla_ctrl_t       ctrl_i,
  input  sfla_in_t         in_item_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output sfla_stat_t       stat_o,
  output logic             res_valid_o,
  output sfla_out_t        res_o
);

  localparam int unsigned ADDR_W = $clog2(POOL_DEPTH);
  localparam int unsigned LINK_W = ADDR_W + 1;
  localparam int unsigned CAP_RST = (POOL_DEPTH < CAP_RESET) ? POOL_DEPTH : CAP_RESET;
  // The top bit of a link marks the end of the list.
  localparam logic [LINK_W-1:0] LINK_END = {1'b1, {ADDR_W{1'b0}}};

  logic [LINK_W-1:0] mem [POOL_DEPTH];
  logic [LINK_W-1:0] rdata_q;

  logic [CAP_W-1:0]  cap_q, cap_sat;
  logic [ADDR_W-1:0] head_q, head_d;
  logic              head_valid_q, head_valid_d;
  logic [CAP_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] sweep_q;
  sfla_in_t          item_q;
  logic              res_valid_q;
  sfla_out_t         res_q, res_d;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr, addr;
  logic [LINK_W-1:0] wdata;
  logic [ADDR_W-1:0] sweep_next;
  logic              link_end;
  logic [ADDR_W-1:0] link_idx;

  assign cap_sat = (32'(cfg_wdata_i) > POOL_DEPTH) ? CAP_W'(POOL_DEPTH) : cfg_wdata_i;

  assign sweep_next = ADDR_W'(sweep_q + 1'b1);
  assign stat_o.sweep_last = (32'(sweep_q) == POOL_DEPTH - 1);

  assign link_end = rdata_q[ADDR_W];
  assign link_idx = rdata_q[ADDR_W-1:0];

  assign raddr = (in_item_i.cmd == CMD_FREE) ? ADDR_W'(in_item_i.slot_index) : head_q;

  always_comb begin
    head_d       = head_q;
    head_valid_d = head_valid_q;
    count_d      = count_q;
    we           = 1'b0;
    waddr        = sweep_q;
    wdata        = LINK_END;
    res_d        = '0;

    if (ctrl_i.init_we) begin
      we = 1'b1;
      if (32'(sweep_q) + 1 < 32'(cap_q)) wdata = {1'b0, sweep_next};
    end

    if (ctrl_i.exec) begin
      if (item_q.cmd == CMD_ALLOC) begin
        if (!head_valid_q || 32'(head_q) >= 32'(cap_q)) begin
          res_d.status = ST_EMPTY;
        end else begin
          if (link_end || 32'(link_idx) >= 32'(cap_q)) begin
            head_valid_d = 1'b0;
            head_d       = '0;
          end else begin
            head_d = link_idx;
          end
          we    = 1'b1;
          waddr = head_q;
          wdata = LINK_END;
          if (count_q != COUNT_MAX) count_d = count_q + 1'b1;
          res_d.granted_slot = SLOT_W'(head_q);
        end
      end else begin
        if (32'(item_q.slot_index) >= 32'(cap_q)) begin
          res_d.status = ST_RANGE;
        end else if (head_valid_q && 32'(head_q) == 32'(item_q.slot_index)) begin
          res_d.status = ST_DOUBLE;
        end else if (rdata_q != LINK_END) begin
          res_d.status = ST_DOUBLE;
        end else begin
          we           = 1'b1;
          waddr        = ADDR_W'(item_q.slot_index);
          wdata        = head_valid_q ? {1'b0, head_q} : LINK_END;
          head_d       = ADDR_W'(item_q.slot_index);
          head_valid_d = 1'b1;
          if (count_q != '0) count_d = count_q - 1'b1;
        end
      end
      res_d.used_count = count_d;
    end
  end

  assign addr = we ? waddr : raddr;

  // Single-port link memory: a write, or a registered read on accept.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (ctrl_i.accept) begin
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) item_q <= in_item_i;
    if (ctrl_i.exec) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_W'(CAP_RST);
      head_q       <= '0;
      head_valid_q <= 1'b1;
      count_q      <= '0;
      sweep_q      <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= ctrl_i.exec;
      if (cfg_we_i) begin
        cap_q        <= cap_sat;
        head_q       <= '0;
        head_valid_q <= (cap_sat != '0);
        count_q      <= '0;
        sweep_q      <= '0;
      end else begin
        head_q       <= head_d;
        head_valid_q <= head_valid_d;
        count_q      <= count_d;
        if (ctrl_i.init_we) sweep_q <= sweep_next;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
